// ===== rtl/ipv4tp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the ipv4 text parser
// no dependencies

package ipv4tp_pkg;

  // default digit limit per part, fixed part limit and default queue depth
  localparam int unsigned MAX_DIGITS_DEF  = 11;
  localparam int unsigned MAX_PARTS       = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // request op codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // ascii codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // per-part range limits
  localparam logic [31:0] LIM_8  = 32'h0000_00FF;
  localparam logic [31:0] LIM_16 = 32'h0000_FFFF;
  localparam logic [31:0] LIM_24 = 32'h00FF_FFFF;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_ZERO,
    TK_DOT,
    TK_XCHAR,
    TK_OTHER,
    TK_END
  } tok_kind_e;

  typedef enum logic [1:0] {
    RM_DEC,
    RM_HEX,
    RM_OCT
  } radix_mode_e;

  // classified character as it travels from front to back
  typedef struct packed {
    tok_kind_e   kind;
    logic [3:0]  dval;
    logic        oct;
  } tok_t;

endpackage

// ===== rtl/ipv4tp_if.sv =====
`timescale 1ns / 1ps
// request and result channel interfaces of the ipv4 text parser
// no dependencies

interface ipv4tp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, op, ch, input ready);
  modport sink   (input valid, op, ch, output ready);
endinterface

interface ipv4tp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        status;

  modport source (output valid, address, status, input ready);
  modport sink   (input valid, address, status, output ready);
endinterface

// ===== rtl/ipv4_text_parser_unit.sv =====
`timescale 1ns / 1ps
// top level of the ipv4 text parser: front, token queue, back
// depends on ipv4tp_pkg, ipv4tp_if, ipv4tp_front, ipv4tp_queue, ipv4tp_back
//
// usage
// - in_req_i carries one request per character (op = 0, ch = ascii code) and
//   one end request (op = 1) that closes the string
// - out_res_o carries one result per end request: address, first byte in the
//   top bits, and status (1 = parse error, address then reads zero)
// - throughput is one request per cycle; a character request is accepted
//   whenever the token queue has room, also while a result waits
// - an end request goes into the token queue, then to the back end, whose
//   output register holds the result; the back end does all per-character
//   work as one shift-add on the part value, setting the one-per-cycle rate
// - when the receiver stalls, the result stays in the output register; the
//   back end keeps working on characters and holds only at the next end
//   request, the queue then fills and in_req_i.ready drops
// - reset clears the queue, the parse state and the output valid; the part
//   store needs no clearing since only written parts are ever read
// - MAX_DIGITS bounds the digits in one part and sets the digit counter width

module ipv4_text_parser_unit
  import ipv4tp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv4tp_in_if.sink     in_req_i,
  ipv4tp_out_if.source  out_res_o
);

  // front to queue
  logic q_in_valid;
  logic q_in_ready;
  tok_t q_in_tok;

  // queue to back
  logic q_out_valid;
  logic q_out_ready;
  tok_t q_out_tok;

  // classify each character into a token
  ipv4tp_front u_front (
    .in_req_i  (in_req_i),
    .q_ready_i (q_in_ready),
    .q_valid_o (q_in_valid),
    .q_tok_o   (q_in_tok)
  );

  // decouples request intake from the result stall
  ipv4tp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_tok_i   (q_in_tok),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_tok_o    (q_out_tok)
  );

  // parse state machine and result register
  ipv4tp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_out_valid),
    .tok_ready_o (q_out_ready),
    .tok_i       (q_out_tok),
    .out_res_o   (out_res_o)
  );

endmodule

// ===== rtl/ipv4tp_front.sv =====
`timescale 1ns / 1ps
// front end: takes character and end requests and classifies them into tokens
// depends on ipv4tp_pkg and ipv4tp_in_if

module ipv4tp_front
  import ipv4tp_pkg::*;
(
  ipv4tp_in_if.sink in_req_i,
  input  logic      q_ready_i,
  output logic      q_valid_o,
  output tok_t      q_tok_o
);

  logic [7:0] num_off;
  logic [7:0] low_off;
  logic [7:0] up_off;

  assign in_req_i.ready = q_ready_i;
  assign q_valid_o      = in_req_i.valid;

  assign num_off = in_req_i.ch - CH_ZERO;
  assign low_off = in_req_i.ch - CH_LA + 8'd10;
  assign up_off  = in_req_i.ch - CH_UA + 8'd10;

  always_comb begin
    q_tok_o.kind = TK_OTHER;
    q_tok_o.dval = 4'd0;
    q_tok_o.oct  = 1'b0;
    if (in_req_i.op == OP_END) begin
      q_tok_o.kind = TK_END;
    end else begin
      q_tok_o.oct = (in_req_i.ch >= CH_ZERO) && (in_req_i.ch <= CH_SEVEN);
      if (in_req_i.ch == CH_DOT) begin
        q_tok_o.kind = TK_DOT;
      end else if (in_req_i.ch == CH_ZERO) begin
        q_tok_o.kind = TK_ZERO;
      end else if (in_req_i.ch >= CH_ONE && in_req_i.ch <= CH_NINE) begin
        q_tok_o.kind = TK_DIGIT;
        q_tok_o.dval = num_off[3:0];
      end else if (in_req_i.ch >= CH_LA && in_req_i.ch <= CH_LF) begin
        q_tok_o.kind = TK_DIGIT;
        q_tok_o.dval = low_off[3:0];
      end else if (in_req_i.ch >= CH_UA && in_req_i.ch <= CH_UF) begin
        q_tok_o.kind = TK_DIGIT;
        q_tok_o.dval = up_off[3:0];
      end else if (in_req_i.ch == CH_LX) begin
        q_tok_o.kind = TK_XCHAR;
      end
    end
  end

endmodule

// ===== rtl/ipv4tp_queue.sv =====
`timescale 1ns / 1ps
// small token queue between front and back
// depends on ipv4tp_pkg

module ipv4tp_queue
  import ipv4tp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  tok_t push_tok_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output tok_t pop_tok_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tok_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_tok_o    = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_tok_i;
    end
  end

endmodule

// ===== rtl/ipv4tp_back.sv =====
`timescale 1ns / 1ps
// back end: digit accumulation, part store, final range checks, result register
// depends on ipv4tp_pkg and ipv4tp_out_if

module ipv4tp_back
  import ipv4tp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  output logic          tok_ready_o,
  input  tok_t          tok_i,
  ipv4tp_out_if.source  out_res_o
);

  localparam int unsigned CW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned PCW = $clog2(MAX_PARTS + 2);
  localparam int unsigned PIW = $clog2(MAX_PARTS);

  radix_mode_e    mode_q, mode_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           zp_q, zp_d;
  logic [31:0]    val_q, val_d;
  logic           over_q, over_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic           err_q, err_d;
  logic [31:0]    parts_q [MAX_PARTS];
  logic           st_we;
  logic           out_valid_q, out_valid_d;
  logic [31:0]    address_q, address_d;
  logic           status_q, status_d;

  logic           take, is_end;
  logic           resolve_x, to_oct, zero_digit;
  radix_mode_e    mode_eff;
  logic [CW-1:0]  cnt_eff;
  logic [35:0]    scaled, next_val;
  logic           push_ok, bad_digit;
  logic           fin, fin_err, range_bad;
  logic [PCW-1:0] pc_eff;
  logic [31:0]    p_eff [MAX_PARTS];
  logic [31:0]    addr;

  assign is_end      = (tok_i.kind == TK_END);
  assign tok_ready_o = !is_end || !out_valid_q || out_res_o.ready;
  assign take        = tok_valid_i & tok_ready_o;

  // a pending leading zero is settled by the next token
  assign resolve_x  = zp_q && (tok_i.kind == TK_XCHAR);
  assign to_oct     = zp_q && !resolve_x && (mode_q != RM_HEX) && tok_i.oct;
  assign zero_digit = zp_q && !resolve_x && !to_oct;
  assign mode_eff   = to_oct ? RM_OCT : mode_q;
  // value is still zero when the leading zero becomes a digit
  assign cnt_eff    = zero_digit ? CW'(1) : cnt_q;

  always_comb begin
    case (mode_eff)
      RM_HEX:  scaled = {val_q, 4'b0};
      RM_OCT:  scaled = {1'b0, val_q, 3'b0};
      default: scaled = {1'b0, val_q, 3'b0} + {3'b0, val_q, 1'b0};
    endcase
  end

  assign next_val  = scaled + {32'b0, tok_i.dval};
  assign push_ok   = (cnt_eff < CW'(MAX_DIGITS));
  assign bad_digit = ((mode_eff == RM_DEC) && (tok_i.dval > 4'd9)) ||
                     ((mode_eff == RM_OCT) && (tok_i.dval > 4'd7));

  // end of string: close the open part and check the layout
  assign fin     = (cnt_eff != '0);
  assign fin_err = fin && ((pc_q >= PCW'(MAX_PARTS)) || over_q);
  assign pc_eff  = pc_q + PCW'(fin);

  always_comb begin
    for (int i = 0; i < MAX_PARTS; i++) begin
      p_eff[i] = (fin && (pc_q == PCW'(i))) ? val_q : parts_q[i];
    end
  end

  always_comb begin
    range_bad = 1'b0;
    addr      = '0;
    case (pc_eff)
      PCW'(1): begin
        addr = p_eff[0];
      end
      PCW'(2): begin
        range_bad = (p_eff[0] > LIM_8) || (p_eff[1] > LIM_24);
        addr      = {p_eff[0][7:0], p_eff[1][23:0]};
      end
      PCW'(3): begin
        range_bad = (p_eff[0] > LIM_8) || (p_eff[1] > LIM_8) || (p_eff[2] > LIM_16);
        addr      = {p_eff[0][7:0], p_eff[1][7:0], p_eff[2][15:0]};
      end
      PCW'(4): begin
        range_bad = (p_eff[0] > LIM_8) || (p_eff[1] > LIM_8) ||
                    (p_eff[2] > LIM_8) || (p_eff[3] > LIM_8);
        addr      = {p_eff[0][7:0], p_eff[1][7:0], p_eff[2][7:0], p_eff[3][7:0]};
      end
      default: begin
        range_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    zp_d        = zp_q;
    val_d       = val_q;
    over_d      = over_q;
    pc_d        = pc_q;
    err_d       = err_q;
    st_we       = 1'b0;
    out_valid_d = out_valid_q && !out_res_o.ready;
    address_d   = address_q;
    status_d    = status_q;
    if (take) begin
      if (is_end) begin
        out_valid_d = 1'b1;
        status_d    = err_q || fin_err || range_bad;
        address_d   = status_d ? '0 : addr;
        mode_d      = RM_DEC;
        cnt_d       = '0;
        zp_d        = 1'b0;
        val_d       = '0;
        over_d      = 1'b0;
        pc_d        = '0;
        err_d       = 1'b0;
      end else if (!err_q) begin
        mode_d = mode_eff;
        cnt_d  = cnt_eff;
        zp_d   = 1'b0;
        if (resolve_x) begin
          mode_d = RM_HEX;
        end else begin
          case (tok_i.kind)
            TK_DOT: begin
              if (cnt_eff == '0 || pc_q >= PCW'(MAX_PARTS) || over_q) begin
                err_d = 1'b1;
              end else begin
                st_we  = 1'b1;
                pc_d   = pc_q + PCW'(1);
                mode_d = RM_DEC;
                cnt_d  = '0;
                val_d  = '0;
                over_d = 1'b0;
              end
            end
            TK_ZERO, TK_DIGIT: begin
              if (tok_i.kind == TK_ZERO && cnt_eff == '0) begin
                zp_d = 1'b1;
              end else if (!push_ok || bad_digit) begin
                err_d = 1'b1;
              end else begin
                val_d  = next_val[31:0];
                over_d = over_q | (|next_val[35:32]);
                cnt_d  = cnt_eff + CW'(1);
              end
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= RM_DEC;
      cnt_q       <= '0;
      zp_q        <= 1'b0;
      val_q       <= '0;
      over_q      <= 1'b0;
      pc_q        <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      zp_q        <= zp_d;
      val_q       <= val_d;
      over_q      <= over_d;
      pc_q        <= pc_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    address_q <= address_d;
    status_q  <= status_d;
    if (st_we) begin
      parts_q[pc_q[PIW-1:0]] <= val_q;
    end
  end

  assign out_res_o.valid   = out_valid_q;
  assign out_res_o.address = address_q;
  assign out_res_o.status  = status_q;

endmodule

// ===== rtl/ipv4tp_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the ipv4 text parser, bound to the top level
// depends on ipv4_text_parser_unit

module ipv4tp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] address_i,
  input logic        status_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(address_i) && $stable(status_i))
    else $error("result changed under stall");

  // an error result carries a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> address_i == 32'h0)
    else $error("error result with nonzero address");

  // no result while in reset
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // with no result pending the queue drains, so requests are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!out_valid_i) |-> in_ready_i)
    else $error("request stalled without a pending result");

endmodule

bind ipv4_text_parser_unit ipv4tp_checker u_ipv4tp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_req_i.valid),
  .in_ready_i  (in_req_i.ready),
  .out_valid_i (out_res_o.valid),
  .out_ready_i (out_res_o.ready),
  .address_i   (out_res_o.address),
  .status_i    (out_res_o.status)
);

// ===== sim/ipv4tp_checker.sv =====
`timescale 1ns / 1ps
// result checker of the ipv4 text parser: rebuilds each address from the request stream
// depends on ipv4tp_pkg and ipv4tp_if

module ipv4tp_result_checker
  import ipv4tp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ipv4tp_in_if  in_req_i,
  ipv4tp_out_if out_res_i,
  output int    mismatch_count_o,
  output int    awaited_o,
  output int    results_seen_o
);

  typedef struct {
    logic [31:0] address;
    logic        status;
  } addr_result_t;

  addr_result_t expected_addrs[$];

  // parse state of the string being read
  logic [63:0]  cur_value;
  int unsigned  cur_digits;
  radix_mode_e  cur_radix;
  logic         zero_held;
  logic [31:0]  part_vals [MAX_PARTS];
  int unsigned  part_total;
  logic         parse_failed;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count_o++;
  endtask

  function void clear_part();
    cur_value  = '0;
    cur_digits = 0;
    cur_radix  = RM_DEC;
    zero_held  = 1'b0;
  endfunction

  function int digit_of(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function void add_digit(int unsigned d);
    logic [63:0] base;
    base = (cur_radix == RM_HEX) ? 64'd16 : (cur_radix == RM_OCT) ? 64'd8 : 64'd10;
    if (cur_digits >= MAX_DIGITS) begin
      parse_failed = 1'b1;
      return;
    end
    cur_value  = cur_value * base + 64'(d);
    cur_digits = cur_digits + 1;
  endfunction

  function void close_part();
    if (part_total >= MAX_PARTS || cur_value > 64'hFFFF_FFFF) begin
      parse_failed = 1'b1;
      return;
    end
    part_vals[part_total] = cur_value[31:0];
    part_total = part_total + 1;
    clear_part();
  endfunction

  function void take_char(logic [7:0] c);
    int d;
    if (c == CH_DOT) begin
      if (cur_digits == 0) parse_failed = 1'b1;
      else close_part();
      return;
    end
    if (c == CH_ZERO) begin
      zero_held = 1'b1;
      return;
    end
    d = digit_of(c);
    if (d < 0 || (cur_radix == RM_DEC && d > 9) || (cur_radix == RM_OCT && d > 7)) begin
      parse_failed = 1'b1;
      return;
    end
    add_digit(d);
  endfunction

  // a held zero meets its next character; returns 1 when that character is used up
  function bit resolve_zero(logic [7:0] c);
    zero_held = 1'b0;
    if (c == CH_LX) begin
      if (cur_digits != 0) parse_failed = 1'b1;
      else cur_radix = RM_HEX;
      return 1'b1;
    end
    if (cur_digits == 0 && cur_radix != RM_HEX && c >= CH_ZERO && c <= CH_SEVEN) begin
      cur_radix = RM_OCT;
      return 1'b0;
    end
    add_digit(0);
    return 1'b0;
  endfunction

  function void predict_request(logic op, logic [7:0] c);
    bit           used;
    logic         ok;
    logic [31:0]  a;
    addr_result_t r;
    if (op == OP_CHAR) begin
      if (!parse_failed) begin
        used = 1'b0;
        if (zero_held) used = resolve_zero(c);
        if (!used && !parse_failed) take_char(c);
      end
      return;
    end
    if (!parse_failed && zero_held) begin
      zero_held = 1'b0;
      add_digit(0);
    end
    if (!parse_failed && cur_digits > 0) close_part();
    ok = !parse_failed;
    a  = '0;
    if (ok) begin
      case (part_total)
        1: a = part_vals[0];
        2: begin
          if (part_vals[0] > LIM_8 || part_vals[1] > LIM_24) ok = 1'b0;
          else a = {part_vals[0][7:0], part_vals[1][23:0]};
        end
        3: begin
          if (part_vals[0] > LIM_8 || part_vals[1] > LIM_8 || part_vals[2] > LIM_16) ok = 1'b0;
          else a = {part_vals[0][7:0], part_vals[1][7:0], part_vals[2][15:0]};
        end
        4: begin
          if (part_vals[0] > LIM_8 || part_vals[1] > LIM_8 || part_vals[2] > LIM_8 ||
              part_vals[3] > LIM_8) ok = 1'b0;
          else a = {part_vals[0][7:0], part_vals[1][7:0], part_vals[2][7:0],
                    part_vals[3][7:0]};
        end
        default: ok = 1'b0;
      endcase
    end
    r.address = ok ? a : 32'h0;
    r.status  = !ok;
    expected_addrs.push_back(r);
    clear_part();
    part_total   = 0;
    parse_failed = 1'b0;
  endfunction

  task automatic check_result(input logic [31:0] address, input logic status);
    addr_result_t r;
    results_seen_o++;
    if (expected_addrs.size() == 0) begin
      report_mismatch($sformatf("result %08h/%0b with no end request waiting", address, status));
      return;
    end
    r = expected_addrs.pop_front();
    if (address !== r.address)
      report_mismatch($sformatf("address %08h, predicted %08h", address, r.address));
    if (status !== r.status)
      report_mismatch($sformatf("status %0b, predicted %0b", status, r.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_part();
      part_total   = 0;
      parse_failed = 1'b0;
      expected_addrs.delete();
      awaited_o = 0;
    end else begin
      if (in_req_i.valid && in_req_i.ready) predict_request(in_req_i.op, in_req_i.ch);
      if (out_res_i.valid && out_res_i.ready) check_result(out_res_i.address, out_res_i.status);
      awaited_o = expected_addrs.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top of the ipv4 text parser: clock, reset, request and result drivers, verdict
// depends on ipv4tp_pkg, ipv4tp_if, ipv4tp_result_checker and ipv4_text_parser_unit

module tb_top;
  import ipv4tp_pkg::*;

  // no movement on either channel for this long means the block hung
  localparam int unsigned IDLE_LIMIT      = 2000;
  // long receiver stall, enough to fill the token queue and back up the input
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned RANDOM_REQUESTS = 320;
  localparam int unsigned MIN_STRINGS     = 20;
  // extra settling time after the last result, before the verdict
  localparam int unsigned DRAIN_CYCLES    = 20;

  logic clk;
  logic rst_n;

  ipv4tp_in_if  in_req ();
  ipv4tp_out_if out_res ();

  int mismatches;
  int awaited;
  int results_seen;

  int unsigned requests_sent;
  int unsigned strings_sent;
  int unsigned idle_cycles;

  // shared between the request and result drivers
  bit no_idle;
  bit hold_results;

  // characters of the string about to be sent
  logic [7:0] text_q[$];

  ipv4_text_parser_unit dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_req_i  (in_req),
    .out_res_o (out_res)
  );

  ipv4tp_result_checker #(
    .MAX_DIGITS (MAX_DIGITS_DEF)
  ) result_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_req_i         (in_req),
    .out_res_i        (out_res),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited),
    .results_seen_o   (results_seen)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // request side helpers
  // ---------------------------------------------------------------------------

  // one request: optional idle gap, then hold valid until ready is seen;
  // ready is looked at on the falling edge so the accepting rising edge is known
  task automatic send_request(input logic op, input logic [7:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.op    <= op;
    in_req.ch    <= c;
    in_req.valid <= 1'b1;
    @(negedge clk);
    while (!in_req.ready) @(negedge clk);
    @(posedge clk);
    requests_sent++;
  endtask

  // the whole string, then its end request with a random don't-care character
  task automatic send_text();
    foreach (text_q[i]) send_request(OP_CHAR, text_q[i]);
    send_request(OP_END, 8'($urandom_range(0, 255)));
    strings_sent++;
  endtask

  // drop valid at the accepting edge, step to the next clock, then wait for all results
  task automatic pause_until_drained();
    in_req.valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
  endtask

  function automatic void append_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // character mix biased toward what the parser reacts to
  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 255));
      1: return CH_ZERO + 8'($urandom_range(0, 9));
      2: return CH_DOT;
      3: return CH_LX;
      4: return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'($urandom_range(0, 5));
      default: return CH_ZERO;
    endcase
  endfunction

  // well-formed address text: 1 to 4 parts (now and then 5), each in a
  // random radix, values mostly in range with the range edges favored
  task automatic build_address();
    int          n;
    logic [63:0] lim;
    logic [63:0] v;
    string       digits;
    text_q.delete();
    n = ($urandom_range(0, 15) == 0) ? 5 : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) text_q.push_back(CH_DOT);
      if (i < n - 1 || n >= 4) lim = 64'hFF;
      else if (n == 1) lim = 64'hFFFF_FFFF;
      else if (n == 2) lim = 64'hFF_FFFF;
      else lim = 64'hFFFF;
      case ($urandom_range(0, 9))
        0: v = 64'h0;
        1: v = lim;
        2: v = lim + 64'd1 + 64'($urandom_range(0, 3));
        3: v = {$urandom, $urandom} >> $urandom_range(16, 40);
        default: v = 64'($urandom) % (lim + 64'd1);
      endcase
      case ($urandom_range(0, 2))
        0: append_chars($sformatf("%0d", v));
        1: begin
          digits = $sformatf("%0h", v);
          if ($urandom_range(0, 2) == 0) digits = digits.toupper();
          append_chars("0x");
          repeat ($urandom_range(0, 2)) text_q.push_back(CH_ZERO);
          append_chars(digits);
        end
        default: append_chars($sformatf("0%0o", v));
      endcase
    end
    // trailing dot now and then
    if ($urandom_range(0, 11) == 0) text_q.push_back(CH_DOT);
  endtask

  // break a well-formed string at one random place
  task automatic mutate_text();
    int pos;
    if (text_q.size() == 0) text_q.push_back(random_char());
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0: text_q[pos] = random_char();
      1: text_q.delete(pos);
      2: text_q.insert(pos, random_char());
      default: text_q.insert(pos, CH_DOT);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // main stimulus
  // ---------------------------------------------------------------------------
  initial begin
    // directed strings: prefixes, held zero cases, limits, part count errors
    string directed_cases[];
    directed_cases = '{
      "", "0", "255.255.255.255", "0.0.0.0", "0X1", "017.0x1.0377.9", "08",
      "0x0ff", "00x1", "10x", "x1", "1..2", "1.2.3.4.5", "4294967295",
      "4294967296", "0xffffffff", "123456789012", "1.2.", "1.16777216",
      "1.2.65535", "256.1.2.3", "018", ".", "0x", "1.0x"
    };

    rst_n        = 1'b0;
    in_req.valid = 1'b0;
    in_req.op    = OP_CHAR;
    in_req.ch    = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cases[i]) begin
      text_q.delete();
      append_chars(directed_cases[i]);
      send_text();
    end
    // all-ones and all-zero character codes
    text_q.delete();
    text_q.push_back(CH_ONE);
    text_q.push_back(8'hFF);
    send_text();
    text_q.delete();
    text_q.push_back(8'h00);
    send_text();

    // sender waits for every outstanding result before the stall test
    pause_until_drained();

    // receiver stalls for a long stretch while requests arrive back to back,
    // so the block holds at an end request and the input backs up
    hold_results = 1'b1;
    no_idle      = 1'b1;
    repeat (12) begin
      build_address();
      send_text();
    end
    no_idle = 1'b0;
    pause_until_drained();
    wait (!hold_results);

    // random strings: mostly well-formed, some broken, some noise
    begin
      int unsigned start_requests;
      int unsigned start_strings;
      start_requests = requests_sent;
      start_strings  = strings_sent;
      while (requests_sent - start_requests < RANDOM_REQUESTS ||
             strings_sent - start_strings < MIN_STRINGS) begin
        // at every eighth string, pick again between idling and full-rate stretches
        if (strings_sent % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
          7, 8: begin
            build_address();
            mutate_text();
          end
          9: begin
            text_q.delete();
            repeat ($urandom_range(0, 10)) text_q.push_back(random_char());
          end
          default: build_address();
        endcase
        send_text();
      end
    end
    no_idle = 1'b0;

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d strings in %0d requests, checked %0d results, %0d mismatches",
             strings_sent, requests_sent, results_seen, mismatches);
    $display("decimal, octal, hex and broken strings, full-rate bursts, one long result stall");
    if (mismatches == 0 && awaited == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random hold-off per result, plus the one long stall
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    out_res.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        out_res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      @(negedge clk);
      while (!out_res.valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run if neither channel moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, awaited);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/ipv4tp_pkg.sv
rtl/ipv4tp_if.sv
rtl/ipv4tp_front.sv
rtl/ipv4tp_queue.sv
rtl/ipv4tp_back.sv
rtl/ipv4_text_parser_unit.sv
rtl/ipv4tp_checker.sv
sim/ipv4tp_checker.sv
sim/tb_top.sv
